@@ rtl/csort_pkg.sv @@
// ----------------------------------------------------------------------------
// csort_pkg
// Shared types for the cocktail shaker sorter: channel words, datapath
// command and status groups, and datapath operation codes.
// ----------------------------------------------------------------------------
package csort_pkg;

    localparam int unsigned VALUE_W = 32;

    // input channel word
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      batch_end;
    } t_in_word;

    // output channel word
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      run_end;
        logic                      overflowed;
    } t_out_word;

    // source of the store write data
    typedef enum logic [1:0] {
        WS_INPUT,
        WS_LOW,
        WS_HIGH,
        WS_CARRY
    } t_wsel;

    // update of the carry register
    typedef enum logic [1:0] {
        CO_HOLD,
        CO_LOAD,
        CO_HIGH,
        CO_LOW
    } t_carry_op;

    // controller to datapath
    typedef struct packed {
        logic      mem_we;
        t_wsel     wsel;
        t_carry_op carry_op;
        logic      swap_clr;
        logic      swap_upd;
        logic      dir_back;
        logic      out_load;
        logic      out_last;
        logic      out_ovf;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic swapped;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/csort_dp.sv @@
// ----------------------------------------------------------------------------
// csort_dp
// Sorter datapath: value store, carry register with compare/min/max,
// pass swap flag and the output word register.
// ----------------------------------------------------------------------------
module csort_dp #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned IW        = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csort_pkg::t_dp_cmd                  i_cmd,
    input  logic [IW-1:0]                       i_rd_addr,
    input  logic [IW-1:0]                       i_wr_addr,
    input  logic signed [csort_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_out_stall,
    output csort_pkg::t_dp_stat                 o_stat,
    output logic                                o_out_valid,
    output csort_pkg::t_out_word                o_out_word
);
    import csort_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [MAX_ITEMS];
    logic signed [VALUE_W-1:0] r_rdata;
    logic signed [VALUE_W-1:0] r_carry;
    logic signed [VALUE_W-1:0] n_carry;
    logic signed [VALUE_W-1:0] w_low;
    logic signed [VALUE_W-1:0] w_high;
    logic signed [VALUE_W-1:0] w_wdata;
    logic                      w_carry_gt;
    logic                      w_pair_gt;
    logic                      r_swapped;
    logic                      r_ovalid;
    t_out_word                 r_oword;

    // compare the carried value with the word just read
    assign w_carry_gt = r_carry > r_rdata;
    assign w_low      = w_carry_gt ? r_rdata : r_carry;
    assign w_high     = w_carry_gt ? r_carry : r_rdata;
    // lower-index element greater than higher-index element
    assign w_pair_gt  = i_cmd.dir_back ? (r_rdata > r_carry) : w_carry_gt;

    // write data select
    always_comb begin
        unique case (i_cmd.wsel)
            WS_INPUT: w_wdata = i_value;
            WS_LOW:   w_wdata = w_low;
            WS_HIGH:  w_wdata = w_high;
            WS_CARRY: w_wdata = r_carry;
            default:  w_wdata = r_carry;
        endcase
    end

    // value store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_wr_addr] <= w_wdata;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    // carry register
    always_comb begin
        case (i_cmd.carry_op)
            CO_LOAD: n_carry = r_rdata;
            CO_HIGH: n_carry = w_high;
            CO_LOW:  n_carry = w_low;
            default: n_carry = r_carry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    // swap seen in the current pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swapped <= 1'b0;
        end else if (i_cmd.swap_clr) begin
            r_swapped <= 1'b0;
        end else if (i_cmd.swap_upd && w_pair_gt) begin
            r_swapped <= 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oword.sorted_value <= r_rdata;
            r_oword.run_end      <= i_cmd.out_last;
            r_oword.overflowed   <= i_cmd.out_ovf;
        end
    end

    assign o_stat.swapped  = r_swapped;
    assign o_stat.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid     = r_ovalid;
    assign o_out_word      = r_oword;

endmodule

@@ rtl/csort_ctrl.sv @@
// ----------------------------------------------------------------------------
// csort_ctrl
// Sorter controller: batch fill count, overflow flag, pass bounds and the
// sequencer for load, forward pass, backward pass and drain.
// ----------------------------------------------------------------------------
module csort_ctrl #(
    parameter int unsigned MAX_ITEMS = 64,
    parameter int unsigned IW        = 6,
    parameter int unsigned CW        = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_batch_end,
    output logic                o_in_stall,
    input  csort_pkg::t_dp_stat i_stat,
    output csort_pkg::t_dp_cmd  o_cmd,
    output logic [IW-1:0]       o_rd_addr,
    output logic [IW-1:0]       o_wr_addr
);
    import csort_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FPRIME = 4'd1;
    localparam logic [3:0] S_FLOAD  = 4'd2;
    localparam logic [3:0] S_FWD    = 4'd3;
    localparam logic [3:0] S_FEND   = 4'd4;
    localparam logic [3:0] S_BPRIME = 4'd5;
    localparam logic [3:0] S_BLOAD  = 4'd6;
    localparam logic [3:0] S_BWD    = 4'd7;
    localparam logic [3:0] S_BEND   = 4'd8;
    localparam logic [3:0] S_OREAD  = 4'd9;
    localparam logic [3:0] S_OLOAD  = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_first, n_first;
    logic [IW-1:0] r_last, n_last;
    logic [IW-1:0] r_idx, n_idx;
    logic          w_full;
    logic [CW-1:0] w_count_new;
    logic          w_is_last;

    assign w_full      = !(r_count < CW'(MAX_ITEMS));
    assign w_count_new = w_full ? r_count : r_count + CW'(1);
    assign w_is_last   = (CW'(r_idx) == r_count - CW'(1));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_first   = r_first;
        n_last    = r_last;
        n_idx     = r_idx;
        o_in_stall = 1'b1;
        o_rd_addr = r_idx;
        o_wr_addr = r_idx;
        o_cmd     = '{mem_we: 1'b0, wsel: WS_INPUT, carry_op: CO_HOLD,
                      swap_clr: 1'b0, swap_upd: 1'b0, dir_back: 1'b0,
                      out_load: 1'b0, out_last: 1'b0, out_ovf: r_ovf};

        unique case (r_state)
            // take words into the store
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_wr_addr  = r_count[IW-1:0];
                if (i_in_valid) begin
                    o_cmd.mem_we = !w_full;
                    n_count      = w_count_new;
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_batch_end) begin
                        n_first = '0;
                        n_last  = IW'(w_count_new - CW'(1));
                        n_idx   = '0;
                        n_state = (w_count_new < CW'(2)) ? S_OREAD : S_FPRIME;
                    end
                end
            end
            // forward pass: carry the larger value up
            S_FPRIME: begin
                o_rd_addr = r_first;
                n_state   = S_FLOAD;
            end
            S_FLOAD: begin
                o_cmd.carry_op = CO_LOAD;
                o_cmd.swap_clr = 1'b1;
                o_rd_addr      = r_first + IW'(1);
                n_idx          = r_first;
                n_state        = S_FWD;
            end
            S_FWD: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.wsel     = WS_LOW;
                o_cmd.carry_op = CO_HIGH;
                o_cmd.swap_upd = 1'b1;
                o_rd_addr      = r_idx + IW'(2);
                if (r_idx + IW'(1) == r_last) begin
                    n_state = S_FEND;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_FEND: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_CARRY;
                o_wr_addr    = r_last;
                n_last       = r_last - IW'(1);
                n_idx        = '0;
                if (i_stat.swapped && (r_first < r_last - IW'(1))) begin
                    n_state = S_BPRIME;
                end else begin
                    n_state = S_OREAD;
                end
            end
            // backward pass: carry the smaller value down
            S_BPRIME: begin
                o_rd_addr = r_last;
                n_state   = S_BLOAD;
            end
            S_BLOAD: begin
                o_cmd.carry_op = CO_LOAD;
                o_cmd.swap_clr = 1'b1;
                o_rd_addr      = r_last - IW'(1);
                n_idx          = r_last;
                n_state        = S_BWD;
            end
            S_BWD: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.wsel     = WS_HIGH;
                o_cmd.carry_op = CO_LOW;
                o_cmd.swap_upd = 1'b1;
                o_cmd.dir_back = 1'b1;
                o_rd_addr      = r_idx - IW'(2);
                if (r_idx - IW'(1) == r_first) begin
                    n_state = S_BEND;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_BEND: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_CARRY;
                o_wr_addr    = r_first;
                n_first      = r_first + IW'(1);
                n_idx        = '0;
                if (i_stat.swapped && (r_first + IW'(1) < r_last)) begin
                    n_state = S_FPRIME;
                end else begin
                    n_state = S_OREAD;
                end
            end
            // drain the sorted batch
            S_OREAD: begin
                n_state = S_OLOAD;
            end
            S_OLOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = w_is_last;
                    if (w_is_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_OREAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // pass bounds and element index
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_last  <= n_last;
        r_idx   <= n_idx;
    end

endmodule

@@ rtl/cocktail_shaker_sorter.sv @@
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter
// Batch sorter for signed 32-bit values: collects words up to a batch end,
// sorts them ascending by cocktail shaker sort and streams them out.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------------
//   in      | input     | i_in_valid/o_in_stall | value, batch_end
//   out     | output    | o_out_valid/i_out_stall | sorted_value, run_end,
//           |           |                      | overflowed
//
// Loading takes one input word per cycle. The sort runs one compare-swap a
// cycle through a store with one read and one write port and a carry register;
// each pass adds prime, load and end steps. Draining reads each word from the
// store, then loads it into the output register, before reading the next one.
// The input stays stalled from the batch end until the last word is loaded
// into the output register; output stalls only hold the drain.
// Reset is synchronous and empties the batch; store contents are not cleared.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  csort_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output csort_pkg::t_out_word o_out_word
);
    import csort_pkg::*;

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;

    // sequencer
    csort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_batch_end (i_in_word.batch_end),
        .o_in_stall  (o_in_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr)
    );

    // store, compare and output register
    csort_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .IW        (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_wr_addr   (w_wr_addr),
        .i_value     (i_in_word.value),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // store writes stay inside the configured depth
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_we |-> (32'(w_wr_addr) < MAX_ITEMS))
        else $error("store write beyond depth");

    // no input word is taken while a sort pass is running
    a_pass_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.swap_upd |-> o_in_stall)
        else $error("input accepted during sort pass");

    // output register loaded only when it is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output word overwritten");

    // last load of a batch shows up as a run end word
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.out_last) |=> (o_out_valid && o_out_word.run_end))
        else $error("run end word missing");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cocktail shaker sorter. A short table of
// directed words (field extremes, duplicates, reversed order) is followed by
// random batches of mixed size and content, including batches that fill the
// store and batches that overrun it. Every accepted input word updates a
// local batch predictor; each accepted output word is compared field by
// field with the oldest predicted word. Both channels idle and stall at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import csort_pkg::*;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RANDOM_WORDS = 340;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_LIMIT   = 20000;
    localparam int unsigned DRAIN_PAUSE  = 50;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // content pattern of a random batch
    typedef enum {
        FILL_WIDE,
        FILL_NARROW,
        FILL_RISING,
        FILL_FALLING,
        FILL_EDGES
    } t_fill;

    // directed row: input word, plus a typed-in result where one is obvious
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // batch predictor state
    logic signed [VALUE_W-1:0] batch_store [DEPTH];
    int unsigned               batch_fill;
    bit                        batch_dropped;
    t_out_word                 sorted_expect [$];

    // run statistics
    int unsigned words_sent;
    int unsigned batches_done;
    int unsigned overflow_batches;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned idle_cycles;

    // pacing of both channels
    bit          sender_burst;
    bit          hold_done;
    bit          stall_on;
    int unsigned stall_left;

    t_dir_row directed [22];

    cocktail_shaker_sorter #(
        .MAX_ITEMS(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // store one word; on a batch end sort the batch and queue its words
    function automatic void absorb_word(input t_in_word w);
        logic signed [VALUE_W-1:0] tmp;
        t_out_word                 res;
        int                        lo;
        int                        hi;
        int                        k;
        bit                        moved;
        if (batch_fill < DEPTH) begin
            batch_store[batch_fill] = w.value;
            batch_fill++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!w.batch_end) return;

        // shaker passes, bounds closing in until a pass moves nothing
        lo    = 0;
        hi    = int'(batch_fill) - 1;
        moved = 1'b1;
        while (moved && lo < hi) begin
            moved = 1'b0;
            for (k = lo; k < hi; k++) begin
                if (batch_store[k] > batch_store[k+1]) begin
                    tmp                = batch_store[k];
                    batch_store[k]     = batch_store[k+1];
                    batch_store[k+1]   = tmp;
                    moved              = 1'b1;
                end
            end
            hi--;
            if (moved) begin
                moved = 1'b0;
                for (k = hi; k > lo; k--) begin
                    if (batch_store[k-1] > batch_store[k]) begin
                        tmp              = batch_store[k-1];
                        batch_store[k-1] = batch_store[k];
                        batch_store[k]   = tmp;
                        moved            = 1'b1;
                    end
                end
                lo++;
            end
        end

        for (k = 0; k < int'(batch_fill); k++) begin
            res.sorted_value = batch_store[k];
            res.run_end      = (k == int'(batch_fill) - 1);
            res.overflowed   = batch_dropped;
            sorted_expect.push_back(res);
        end
        batches_done++;
        if (batch_dropped) overflow_batches++;
        batch_fill    = 0;
        batch_dropped = 1'b0;
    endfunction

    // sender gap before a word: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (sender_burst) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // value of word idx within a random batch
    function automatic logic signed [VALUE_W-1:0] pick_value(input t_fill fill,
                                                             input int idx);
        case (fill)
            FILL_WIDE:    return $urandom();
            FILL_NARROW:  return int'($urandom_range(0, 6)) - 3;
            FILL_RISING:  return idx * 3 - 40;
            FILL_FALLING: return 5000 - idx * 11;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return MOST_NEG + 1;
                    3:       return MOST_POS - 1;
                    4:       return -1;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    // offer one word, hold it until taken, then update the predictor
    task automatic send_word(input t_in_word w, input bit typed,
                             input t_out_word typed_result);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        absorb_word(w);
        // a typed-in result stands in for the predicted one
        if (typed) begin
            void'(sorted_expect.pop_back());
            sorted_expect.push_back(typed_result);
        end
        words_sent++;
    endtask

    // stimulus: reset, directed table, random batches, drain
    initial begin
        t_in_word    w;
        t_fill       fill;
        int unsigned batch_idx;
        int unsigned batch_len;
        int unsigned random_sent;
        int          i;

        directed = '{
            // single-word batches right after reset
            '{'{MOST_NEG, 1'b1}, 1'b1, '{MOST_NEG, 1'b1, 1'b0}},
            '{'{MOST_POS, 1'b1}, 1'b1, '{MOST_POS, 1'b1, 1'b0}},
            '{'{32'sd0,   1'b1}, 1'b1, '{32'sd0,   1'b1, 1'b0}},
            '{'{-32'sd1,  1'b1}, 1'b1, '{-32'sd1,  1'b1, 1'b0}},
            // field extremes mixed, with a duplicate zero
            '{'{MOST_POS,       1'b0}, 1'b0, '0},
            '{'{MOST_NEG,       1'b0}, 1'b0, '0},
            '{'{-32'sd1,        1'b0}, 1'b0, '0},
            '{'{32'sd0,         1'b0}, 1'b0, '0},
            '{'{32'sd1,         1'b0}, 1'b0, '0},
            '{'{MOST_POS - 1,   1'b0}, 1'b0, '0},
            '{'{MOST_NEG + 1,   1'b0}, 1'b0, '0},
            '{'{32'sd0,         1'b1}, 1'b0, '0},
            // all equal
            '{'{32'sd5, 1'b0}, 1'b0, '0},
            '{'{32'sd5, 1'b0}, 1'b0, '0},
            '{'{32'sd5, 1'b0}, 1'b0, '0},
            '{'{32'sd5, 1'b1}, 1'b0, '0},
            // strictly falling
            '{'{32'sd3, 1'b0}, 1'b0, '0},
            '{'{32'sd2, 1'b0}, 1'b0, '0},
            '{'{32'sd1, 1'b0}, 1'b0, '0},
            '{'{32'sd0, 1'b1}, 1'b0, '0},
            // already in order
            '{'{-32'sd5, 1'b0}, 1'b0, '0},
            '{'{32'sd7,  1'b1}, 1'b0, '0}
        };

        batch_fill    = 0;
        batch_dropped = 1'b0;
        sender_burst  = 1'b0;
        random_sent   = 0;
        batch_idx     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r]) begin
            send_word(directed[r].word, directed[r].typed, directed[r].result);
        end

        // random batches: mostly short, a few at and beyond the store size
        while (random_sent < RANDOM_WORDS) begin
            batch_idx++;
            case (batch_idx)
                3:       batch_len = DEPTH + 1;
                6:       batch_len = DEPTH;
                9:       batch_len = DEPTH + 2;
                default: batch_len = ($urandom_range(0, 3) == 0) ?
                                     $urandom_range(9, 20) : $urandom_range(1, 8);
            endcase
            fill         = t_fill'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) fill = FILL_WIDE;
            sender_burst = ($urandom_range(0, 3) == 0);
            for (i = 0; i < int'(batch_len); i++) begin
                w.value     = pick_value(fill, i);
                w.batch_end = (i == int'(batch_len) - 1);
                send_word(w, 1'b0, '0);
            end
            random_sent += batch_len;
        end
        i_in_valid <= 1'b0;

        while (sorted_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);

        $display("run covered %0d input words in %0d batches, %0d sorted words checked",
                 words_sent, batches_done, results_seen);
        $display("%0d batches overran the %0d-word store; receiver held off %0d cycles once",
                 overflow_batches, DEPTH, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // output side: check each taken word, then pick the next stall
    always @(posedge i_clk) begin : out_side
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (sorted_expect.size() == 0) begin
                $error("output word %0h with no expected word", o_out_word);
                mismatches++;
            end else begin
                want = sorted_expect.pop_front();
                if (o_out_word.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, o_out_word.sorted_value);
                    mismatches++;
                end
                if (o_out_word.run_end !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b",
                           want.run_end, o_out_word.run_end);
                    mismatches++;
                end
                if (o_out_word.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, o_out_word.overflowed);
                    mismatches++;
                end
            end
        end

        // one long hold-off so the input side backs up
        if (!hold_done && results_seen >= 40) begin
            hold_done  = 1'b1;
            stall_on   = 1'b1;
            stall_left = HOLD_CYCLES;
        end else if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_on   = ($urandom_range(0, 99) < 30);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
        end
        i_out_stall <= stall_on;
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles, %0d words still expected",
                     IDLE_LIMIT, sorted_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
